>>> src/cfsp_pkg.sv
// Shared types and constants for the command frame slave parser.
`default_nettype none
package cfsp_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'h42;
   localparam logic [7:0] POLL_MASK = 8'h0F;
   localparam logic [7:0] ALL_ONES  = 8'hFF;

   localparam int unsigned MAX_RESULTS = 4;

   localparam logic [1:0] KIND_COMMAND = 2'd0;
   localparam logic [1:0] KIND_POWER   = 2'd1;
   localparam logic [1:0] KIND_PERIOD  = 2'd2;
   localparam logic [1:0] KIND_REPLY   = 2'd3;

   typedef logic [2:0] count_type;
   typedef logic [1:0] slot_type;

   typedef struct packed {
      count_type                       count;
      logic [MAX_RESULTS-1:0][1:0]     kind;
      logic [MAX_RESULTS-1:0][15:0]    value;
   } result_set_type;

endpackage
`default_nettype wire

>>> src/cfsp_parser.sv
// Frame position tracker and per-byte result decode.
`default_nettype none
module cfsp_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               rx_byte,
   input  wire logic [15:0]              measured_voltage,
   input  wire logic [7:0]               status_flags,
   output cfsp_pkg::result_set_type      results
);

   typedef enum logic [3:0] {
      POS_SYNC,
      POS_CMD1,
      POS_CMD2,
      POS_CHECK1,
      POS_CHECK2,
      POS_SIMMER_LO,
      POS_SIMMER_HI,
      POS_POWER_LO,
      POS_POWER_HI,
      POS_PERIOD_LO,
      POS_PERIOD_HI,
      POS_REQ_SKIP,
      POS_REQUEST
   } pos_type;

   pos_type    pos_ff,  pos_in;
   logic [7:0] cmd1_ff, cmd1_in;
   logic [7:0] cmd2_ff, cmd2_in;
   logic [7:0] chk1_ff, chk1_in;
   logic [7:0] low_ff,  low_in;

   always_comb begin
      pos_in  = pos_ff;
      cmd1_in = cmd1_ff;
      cmd2_in = cmd2_ff;
      chk1_in = chk1_ff;
      low_in  = low_ff;
      results = '0;
      case (pos_ff)
         POS_SYNC: begin
            if (rx_byte == cfsp_pkg::SYNC_BYTE) begin
               pos_in = POS_CMD1;
            end
         end
         POS_CMD1: begin
            cmd1_in = rx_byte;
            pos_in  = POS_CMD2;
         end
         POS_CMD2: begin
            cmd2_in = rx_byte;
            pos_in  = POS_CHECK1;
         end
         POS_CHECK1: begin
            chk1_in = rx_byte;
            pos_in  = POS_CHECK2;
         end
         POS_CHECK2: begin
            if ((cmd1_ff == (chk1_ff ^ cfsp_pkg::ALL_ONES)) &&
                (cmd2_ff == (rx_byte ^ cfsp_pkg::ALL_ONES))) begin
               results.count    = 3'd1;
               results.kind[0]  = cfsp_pkg::KIND_COMMAND;
               results.value[0] = {cmd2_ff, cmd1_ff};
            end
            pos_in = POS_SIMMER_LO;
         end
         POS_SIMMER_LO: begin
            pos_in = POS_SIMMER_HI;
         end
         POS_SIMMER_HI: begin
            pos_in = POS_POWER_LO;
         end
         POS_POWER_LO: begin
            low_in = rx_byte;
            pos_in = POS_POWER_HI;
         end
         POS_POWER_HI: begin
            results.count    = 3'd1;
            results.kind[0]  = cfsp_pkg::KIND_POWER;
            results.value[0] = {rx_byte, low_ff};
            pos_in           = POS_PERIOD_LO;
         end
         POS_PERIOD_LO: begin
            low_in = rx_byte;
            pos_in = POS_PERIOD_HI;
         end
         POS_PERIOD_HI: begin
            results.count    = 3'd1;
            results.kind[0]  = cfsp_pkg::KIND_PERIOD;
            results.value[0] = {rx_byte, low_ff};
            pos_in           = POS_REQ_SKIP;
         end
         POS_REQ_SKIP: begin
            pos_in = POS_REQUEST;
         end
         POS_REQUEST: begin
            results.kind[0]  = cfsp_pkg::KIND_REPLY;
            results.value[0] = {8'h00, status_flags};
            results.kind[1]  = cfsp_pkg::KIND_REPLY;
            results.value[1] = 16'h0000;
            results.kind[2]  = cfsp_pkg::KIND_REPLY;
            results.value[2] = {8'h00, measured_voltage[7:0]};
            results.kind[3]  = cfsp_pkg::KIND_REPLY;
            results.value[3] = {8'h00, measured_voltage[15:8]};
            if ((rx_byte & cfsp_pkg::POLL_MASK) == 8'h00) begin
               results.count = 3'd4;
            end else begin
               results.count = 3'd2;
            end
            pos_in = POS_SYNC;
         end
         default: begin
            pos_in = POS_SYNC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_SYNC;
         cmd1_ff <= 8'h00;
         cmd2_ff <= 8'h00;
         chk1_ff <= 8'h00;
         low_ff  <= 8'h00;
      end else if (step) begin
         pos_ff  <= pos_in;
         cmd1_ff <= cmd1_in;
         cmd2_ff <= cmd2_in;
         chk1_ff <= chk1_in;
         low_ff  <= low_in;
      end
   end

`ifndef ASSERT_OFF
   a_request_returns_to_sync: assert property (@(posedge clock) disable iff (reset)
      step && (pos_ff == POS_REQUEST) |=> pos_ff == POS_SYNC)
      else $error("parser did not return to sync wait after request byte");

   a_reply_count: assert property (@(posedge clock) disable iff (reset)
      (results.count != 3'd0) && (results.kind[0] == cfsp_pkg::KIND_REPLY)
      |-> (results.count == 3'd2) || (results.count == 3'd4))
      else $error("reply produced a count other than two or four");

   a_results_only_at_emitting_positions: assert property (@(posedge clock)
      disable iff (reset)
      (results.count != 3'd0) |-> (pos_ff == POS_CHECK2) || (pos_ff == POS_POWER_HI) ||
         (pos_ff == POS_PERIOD_HI) || (pos_ff == POS_REQUEST))
      else $error("results produced at a non-emitting frame position");
`endif

endmodule
`default_nettype wire

>>> src/cfsp_out.sv
// Result bank that holds up to four results and drains them one per transfer.
`default_nettype none
module cfsp_out (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire cfsp_pkg::result_set_type results,
   output logic                          bank_ready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [15:0]                   rsp_tdata,  // value
   output logic [1:0]                    rsp_tuser,  // kind
   output logic                          rsp_tlast
);

   cfsp_pkg::count_type                              total_ff, total_in;
   cfsp_pkg::slot_type                               idx_ff,   idx_in;
   logic [cfsp_pkg::MAX_RESULTS-1:0][1:0]            kind_ff;
   logic [cfsp_pkg::MAX_RESULTS-1:0][15:0]           value_ff;
   logic                                             take;
   logic                                             at_last;

   assign rsp_tvalid = (total_ff != 3'd0);
   assign at_last    = ({1'b0, idx_ff} == (total_ff - 3'd1));
   assign take       = rsp_tvalid && rsp_tready;
   assign bank_ready = !rsp_tvalid || (take && at_last);
   assign rsp_tdata  = value_ff[idx_ff];
   assign rsp_tuser  = kind_ff[idx_ff];
   assign rsp_tlast  = rsp_tvalid && at_last;

   always_comb begin
      total_in = total_ff;
      idx_in   = idx_ff;
      if (load) begin
         total_in = results.count;
         idx_in   = 2'd0;
      end else if (take) begin
         if (at_last) begin
            total_in = 3'd0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         total_ff <= total_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= results.kind;
         value_ff <= results.value;
      end
   end

`ifndef ASSERT_OFF
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (total_ff != 3'd0) |-> ({1'b0, idx_ff} < total_ff))
      else $error("result index beyond bank fill");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> bank_ready)
      else $error("result bank loaded while results still pending");
`endif

endmodule
`default_nettype wire

>>> src/command_frame_slave_parser_core.sv
// Top level of the command frame slave parser: input register, parser and result bank.
//
// Usage:
//   req_* carries one received serial byte per transfer together with the current
//   measured voltage and status byte. rsp_* carries result transfers: tuser is the
//   kind (command update, power setpoint, fire period, reply byte), tdata the
//   16-bit value, tlast marks the last result caused by one input byte.
//   A byte is registered in the input register, and its results are loaded into the
//   result bank once it is free, which presents them on rsp_*. Throughput: one byte per
//   cycle for bytes that cause at most one result, while the receiver accepts; the
//   final request byte occupies the result bank until its two or four reply bytes
//   have drained, since the bank drains one result per cycle while rsp_tready is high.
//   Bytes that cause no result pass through without occupying the output.
//   Reset clears the frame position to sync wait, the command and check bytes,
//   and empties the input register and result bank.
//   When the receiver stalls, results hold in the bank and one further byte
//   waits in the input register before req_tready drops.
`default_nettype none
module command_frame_slave_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // rx_byte, measured_voltage, status_flags
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // value
   output logic [1:0]       rsp_tuser,  // kind
   output logic             rsp_tlast
);

   logic                      in_valid_ff, in_valid_in;
   logic [31:0]               in_data_ff;
   logic                      bank_ready;
   logic                      load;
   logic                      step;
   cfsp_pkg::result_set_type  results;

   assign step       = in_valid_ff && bank_ready;
   assign load       = step && (results.count != 3'd0);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   cfsp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rx_byte          (in_data_ff[7:0]),
      .measured_voltage (in_data_ff[23:8]),
      .status_flags     (in_data_ff[31:24]),
      .results          (results)
   );

   cfsp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .results    (results),
      .bank_ready (bank_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_input_holds_until_step: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a byte before it was parsed");
`endif

endmodule
`default_nettype wire

>>> sim/tb_command_frame_slave_parser_core.sv
// Self-checking testbench for the command frame slave parser: frame traffic against a predictor.
`timescale 1ns / 1ps
module tb_command_frame_slave_parser_core;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MISMATCH_REPORTS = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
      logic        last;
   } parser_output_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // rx_byte, measured_voltage, status_flags
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // value
   logic [1:0]  rsp_tuser;       // kind
   logic        rsp_tlast;

   parser_output_type outputs_due[$];
   parser_output_type head_output;

   logic [3:0] frame_pos = '0;
   logic [7:0] cmd_first = '0;
   logic [7:0] cmd_second = '0;
   logic [7:0] check_first = '0;
   logic [7:0] low_hold = '0;

   bit idle_on = 1'b1;
   int ready_hold = 0;
   int bytes_sent = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   command_frame_slave_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void parse_rx_byte(input logic [7:0] rx, input logic [15:0] volt,
                                         input logic [7:0] stat);
      parser_output_type caused[$];
      case (frame_pos)
         4'd1: cmd_first = rx;
         4'd2: cmd_second = rx;
         4'd3: check_first = rx;
         4'd4: begin
            if (cmd_first == (check_first ^ cfsp_pkg::ALL_ONES) &&
                cmd_second == (rx ^ cfsp_pkg::ALL_ONES))
               caused.push_back({cfsp_pkg::KIND_COMMAND, cmd_second, cmd_first, 1'b0});
         end
         4'd7: low_hold = rx;
         4'd8: caused.push_back({cfsp_pkg::KIND_POWER, rx, low_hold, 1'b0});
         4'd9: low_hold = rx;
         4'd10: caused.push_back({cfsp_pkg::KIND_PERIOD, rx, low_hold, 1'b0});
         4'd12: begin
            caused.push_back({cfsp_pkg::KIND_REPLY, 8'h00, stat, 1'b0});
            caused.push_back({cfsp_pkg::KIND_REPLY, 16'h0000, 1'b0});
            if ((rx & cfsp_pkg::POLL_MASK) == 8'h00) begin
               caused.push_back({cfsp_pkg::KIND_REPLY, 8'h00, volt[7:0], 1'b0});
               caused.push_back({cfsp_pkg::KIND_REPLY, 8'h00, volt[15:8], 1'b0});
            end
         end
         default: ;
      endcase
      if (frame_pos == 4'd0)
         frame_pos = (rx == cfsp_pkg::SYNC_BYTE) ? 4'd1 : 4'd0;
      else if (frame_pos >= 4'd12)
         frame_pos = 4'd0;
      else
         frame_pos = frame_pos + 4'd1;
      if (caused.size() > 0)
         caused[caused.size() - 1].last = 1'b1;
      foreach (caused[i])
         outputs_due.push_back(caused[i]);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] rx, input logic [15:0] volt,
                            input logic [7:0] stat);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {stat, volt, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_rx_byte(rx, volt, stat);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] c1, input logic [7:0] c2,
                             input logic [7:0] chk1, input logic [7:0] chk2,
                             input logic [15:0] power, input logic [15:0] period,
                             input logic [7:0] request, input logic [15:0] volt,
                             input logic [7:0] stat);
      send_byte(cfsp_pkg::SYNC_BYTE, 16'($urandom), 8'($urandom));
      send_byte(c1, 16'($urandom), 8'($urandom));
      send_byte(c2, 16'($urandom), 8'($urandom));
      send_byte(chk1, 16'($urandom), 8'($urandom));
      send_byte(chk2, 16'($urandom), 8'($urandom));
      send_byte(8'($urandom), 16'($urandom), 8'($urandom));
      send_byte(8'($urandom), 16'($urandom), 8'($urandom));
      send_byte(power[7:0], 16'($urandom), 8'($urandom));
      send_byte(power[15:8], 16'($urandom), 8'($urandom));
      send_byte(period[7:0], 16'($urandom), 8'($urandom));
      send_byte(period[15:8], 16'($urandom), 8'($urandom));
      send_byte(8'($urandom), 16'($urandom), 8'($urandom));
      send_byte(request, volt, stat);
   endtask

   task automatic test_sync_hunt();
      send_byte(8'hFF, 16'hFFFF, 8'hFF);
      send_byte(8'h00, 16'h0000, 8'h00);
   endtask

   task automatic test_good_frame();
      send_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF, 16'h0000, 8'hF0, 16'hA55A, 8'hFF);
   endtask

   task automatic test_check_failure();
      send_frame(8'h00, 8'hFF, 8'hFF, 8'h01, 16'h0000, 16'hFFFF, 8'h0F, 16'hFFFF, 8'h00);
   endtask

   task automatic test_random_frames(input int target);
      logic [7:0] c1, c2, chk1, chk2, request;
      int pick;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_byte(8'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            c1 = 8'($urandom);
            c2 = 8'($urandom);
            chk1 = c1 ^ cfsp_pkg::ALL_ONES;
            chk2 = c2 ^ cfsp_pkg::ALL_ONES;
            if (pick == 1)
               chk1 = chk1 ^ (8'h01 << $urandom_range(0, 7));
            else if (pick == 2)
               chk2 = chk2 ^ (8'h01 << $urandom_range(0, 7));
            request = 8'($urandom);
            if ($urandom_range(0, 1) == 0)
               request = request & ~cfsp_pkg::POLL_MASK;
            send_frame(c1, c2, chk1, chk2, 16'($urandom), 16'($urandom), request,
                       16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic test_steady_stream(input int target);
      idle_on = 1'b0;
      test_random_frames(target);
   endtask

   always @(negedge clock) begin
      if (ready_hold > 0)
         ready_hold--;
      else if (idle_on && $urandom_range(0, 5) == 0)
         ready_hold = $urandom_range(1, 18);
      rsp_tready <= (ready_hold == 0);
   end

   task automatic flag_mismatch(input string what, input parser_output_type want);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_REPORTS)
         $display("mismatch (%s): expected kind %0d value %h last %0d, %s %0d %s %h %s %0d",
                  what, want.kind, want.value, want.last, "got kind", rsp_tuser,
                  "value", rsp_tdata, "last", rsp_tlast);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outputs_due.size() == 0) begin
            flag_mismatch("no transfer expected", '0);
         end else begin
            head_output = outputs_due.pop_front();
            if (rsp_tuser !== head_output.kind || rsp_tdata !== head_output.value ||
                rsp_tlast !== head_output.last)
               flag_mismatch("field", head_output);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_sync_hunt();
      test_good_frame();
      test_check_failure();
      test_random_frames(400);
      test_steady_stream(460);
      req_tvalid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (outputs_due.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
